[rtl/core/bctc_pkg.sv]
// Shared types, widths and calendar tables for the BCD calendar to tick count unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bctc_pkg;

  localparam int TimeW   = 23;
  localparam int DateW   = 24;
  localparam int SubW    = 15;
  localparam int FreqW   = 16;
  localparam int InDataW = 64;
  localparam int TickW   = 42;
  localparam int SubtW   = 5;
  localparam int OutDataW = 48;
  localparam int DaysW   = 16;
  localparam int SodW    = 17;
  localparam int SecsW   = 32;

  localparam logic [FreqW-1:0] FreqReset = 16'd32768;
  localparam logic [3:0] MonthFeb = 4'd2;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic       leap;
    logic       ok;
  } fields_t;

  function automatic logic [7:0] bcd2(input logic [3:0] tens, input logic [3:0] units);
    bcd2 = tens * 8'd10 + {4'd0, units};
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month);
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
      4'd2: month_days = 5'd28;
      default: month_days = 5'd0;
    endcase
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] month);
    case (month)
      4'd1: days_before = 9'd0;
      4'd2: days_before = 9'd31;
      4'd3: days_before = 9'd59;
      4'd4: days_before = 9'd90;
      4'd5: days_before = 9'd120;
      4'd6: days_before = 9'd151;
      4'd7: days_before = 9'd181;
      4'd8: days_before = 9'd212;
      4'd9: days_before = 9'd243;
      4'd10: days_before = 9'd273;
      4'd11: days_before = 9'd304;
      4'd12: days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

endpackage

[rtl/core/bctc_field_check.sv]
// BCD decode and calendar range check of one RTC snapshot (combinational).
// Depends on bctc_pkg.
`timescale 1ns / 1ps

module bctc_field_check (
  input  logic [bctc_pkg::TimeW-1:0] time_word,
  input  logic [bctc_pkg::DateW-1:0] date_word,
  input  logic [bctc_pkg::SubW-1:0]  subsecond_down,
  input  logic [bctc_pkg::FreqW-1:0] clock_frequency,
  output bctc_pkg::fields_t          fields
);
  import bctc_pkg::*;

  logic [7:0] sec_b, min_b, hour_b, day_b, month_b, year_b;
  logic       digits_ok;
  logic       leap;
  logic [5:0] mdays;
  logic       range_ok;

  always_comb begin
    sec_b   = bcd2({1'b0, time_word[6:4]}, time_word[3:0]);
    min_b   = bcd2({1'b0, time_word[14:12]}, time_word[11:8]);
    hour_b  = bcd2({2'b0, time_word[21:20]}, time_word[19:16]);
    day_b   = bcd2({2'b0, date_word[5:4]}, date_word[3:0]);
    month_b = bcd2({3'b0, date_word[12]}, date_word[11:8]);
    year_b  = bcd2(date_word[23:20], date_word[19:16]);

    digits_ok = (time_word[3:0] <= 4'd9) && (time_word[11:8] <= 4'd9) &&
                (time_word[19:16] <= 4'd9) && (date_word[3:0] <= 4'd9) &&
                (date_word[11:8] <= 4'd9) && (date_word[19:16] <= 4'd9) &&
                (date_word[23:20] <= 4'd9);

    leap  = (year_b[1:0] == 2'd0);
    mdays = {1'b0, month_days(month_b[3:0])} +
            {5'd0, (month_b == {4'd0, MonthFeb}) && leap};

    range_ok = (sec_b <= 8'd59) && (min_b <= 8'd59) && (hour_b <= 8'd23) &&
               (month_b >= 8'd1) && (month_b <= 8'd12) &&
               (day_b >= 8'd1) && (day_b <= {2'd0, mdays}) &&
               ({1'b0, subsecond_down} < clock_frequency);

    fields.sec   = sec_b[5:0];
    fields.min   = min_b[5:0];
    fields.hour  = hour_b[4:0];
    fields.day   = day_b[4:0];
    fields.month = month_b[3:0];
    fields.year  = year_b[6:0];
    fields.leap  = leap;
    fields.ok    = digits_ok && range_ok;
  end

endmodule

[rtl/core/bcd_calendar_to_tick_count_unit.sv]
// Top level of the BCD calendar to tick count unit: four-stage converter with stream ports.
// Depends on bctc_pkg and bctc_field_check.
`timescale 1ns / 1ps

// Converts an RTC snapshot (BCD time, BCD date with two-digit year 2000-2099,
// down-counting subsecond value) into 1/1024 s ticks since 2000-01-01 00:00:00,
// plus the elapsed subsecond count modulo 32 as subticks. A snapshot with a bad
// BCD digit, an out-of-range calendar field or a subsecond value not below the
// clock frequency comes out with tuser set and zero data. One transfer per cycle
// is taken in steady state while m_axis_tready does not stall the output, set by the
// four-stage pipe (decode, day and second-of-day sums, 16x17 multiply by 86400,
// final scale and add into the output register). Each stage holds only while its
// successor is full and stalled. The clock frequency register resets to 32768; the
// user must see that it is written only when idle, as the block does not enforce it.

module bcd_calendar_to_tick_count_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [bctc_pkg::FreqW-1:0]         cfg_wr_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // time_word [22:0], date_word [46:23], subsecond_down [61:47]
  input  logic [bctc_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tick_count [41:0], subticks [46:42]
  output logic [bctc_pkg::OutDataW-1:0]      m_axis_tdata,
  // invalid [0]
  output logic                               m_axis_tuser
);
  import bctc_pkg::*;

  logic [FreqW-1:0] clock_frequency;

  fields_t          chk;
  logic [15:0]      elapsed;

  logic             v1, v2, v3, vo;
  logic             rdy1, rdy2, rdy3, rdyo;

  fields_t          f1;
  logic [15:0]      e1;

  logic [DaysW-1:0] days2;
  logic [SodW-1:0]  sod2;
  logic [15:0]      e2;
  logic             ok2;
  logic [DaysW-1:0] days_next;
  logic [SodW-1:0]  sod_next;

  logic [SecsW-1:0] secs3;
  logic [15:0]      e3;
  logic             ok3;
  logic [SecsW-1:0] secs_next;

  logic [TickW-1:0] ticks;
  logic [SubtW-1:0] subt;
  logic             inv;
  logic [TickW-1:0] ticks_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_frequency <= FreqReset;
    end else if (cfg_wr_en) begin
      clock_frequency <= cfg_wr_data;
    end
  end

  bctc_field_check u_check (
    .time_word      (s_axis_tdata[22:0]),
    .date_word      (s_axis_tdata[46:23]),
    .subsecond_down (s_axis_tdata[61:47]),
    .clock_frequency(clock_frequency),
    .fields         (chk)
  );

  assign elapsed = clock_frequency - 16'd1 - {1'b0, s_axis_tdata[61:47]};

  assign rdyo = !vo || m_axis_tready;
  assign rdy3 = !v3 || rdyo;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdyo) vo <= v3;
    end
  end

  // stage 1: decoded fields
  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1 <= chk;
      e1 <= elapsed;
    end
  end

  // stage 2: day number and second of day
  always_comb begin
    days_next = 16'(f1.year * 16'd365) + 16'((f1.year + 7'd3) >> 2) +
                {7'd0, days_before(f1.month)} + {11'd0, f1.day} - 16'd1 +
                {15'd0, (f1.month > MonthFeb) && f1.leap};
    sod_next  = 17'(f1.hour * 17'd3600) + 17'(f1.min * 17'd60) + {11'd0, f1.sec};
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      days2 <= days_next;
      sod2  <= sod_next;
      e2    <= e1;
      ok2   <= f1.ok;
    end
  end

  // stage 3: whole seconds
  assign secs_next = 32'(days2 * 32'd86400) + {15'd0, sod2};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      secs3 <= secs_next;
      e3    <= e2;
      ok3   <= ok2;
    end
  end

  // output stage: scale to ticks, zero on bad snapshot
  assign ticks_next = {secs3, 10'd0} + {31'd0, e3[15:5]};

  always_ff @(posedge clk) begin
    if (rdyo) begin
      ticks <= ok3 ? ticks_next : '0;
      subt  <= ok3 ? e3[4:0] : '0;
      inv   <= !ok3;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {1'b0, subt, ticks};
  assign m_axis_tuser  = inv;

endmodule

[bench/tb_bcd_calendar_to_tick_count_unit.sv]
// Testbench for bcd_calendar_to_tick_count_unit: directed calendar and clock-frequency cases,
// random snapshots under random stalls and a long output hold-off, checked against a predictor.
// Depends on bctc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_bcd_calendar_to_tick_count_unit;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 12;
  localparam logic [22:0] TimeSpareBits = 23'h408080;
  localparam logic [23:0] DateSpareBits = 24'h00E0C0;

  typedef struct packed {
    logic [41:0] tick;
    logic [4:0]  subt;
    logic        invalid;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [bctc_pkg::FreqW-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [bctc_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [bctc_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  tick_result_t expected_ticks[$];
  logic [15:0] rtc_freq = 16'd32768;
  int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_ahead [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int holdoff_cycles = 0;
  int mismatches = 0;
  int snapshots_sent = 0;
  int invalid_sent = 0;
  int results_checked = 0;
  int freq_settings = 0;
  int cycle_count = 0;

  bcd_calendar_to_tick_count_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // BCD pair; a digit above 9 maps to 100 so the range checks reject it
  function automatic int unsigned from_bcd(int unsigned tens, int unsigned units);
    if (tens > 9 || units > 9) return 100;
    return tens * 10 + units;
  endfunction

  function automatic tick_result_t convert_snapshot(logic [15:0] freq, logic [22:0] tw,
                                                    logic [23:0] dw, logic [14:0] down);
    int unsigned sec, mins, hrs, day, mon, yr, mdays, elapsed;
    bit ok, leap;
    longint unsigned days, secs;
    tick_result_t r;
    sec  = from_bcd(tw[6:4], tw[3:0]);
    mins = from_bcd(tw[14:12], tw[11:8]);
    hrs  = from_bcd(tw[21:20], tw[19:16]);
    day  = from_bcd(dw[5:4], dw[3:0]);
    mon  = from_bcd(dw[12], dw[11:8]);
    yr   = from_bcd(dw[23:20], dw[19:16]);
    ok = (sec <= 59) && (mins <= 59) && (hrs <= 23) && (yr <= 99);
    leap = (yr % 4) == 0;
    if (mon < 1 || mon > 12) begin
      ok = 1'b0;
    end else begin
      mdays = (mon == 2 && leap) ? 29 : month_len[mon-1];
      if (day < 1 || day > mdays) ok = 1'b0;
    end
    if (down >= freq) ok = 1'b0;
    r = '0;
    if (!ok) begin
      r.invalid = 1'b1;
      return r;
    end
    elapsed = freq - 1 - down;
    days = 365 * yr + (yr + 3) / 4 + days_ahead[mon-1] + day - 1;
    if (mon > 2 && leap) days++;
    secs = days * 86400 + 3600 * hrs + 60 * mins + sec;
    r.tick = 42'(secs * 1024 + elapsed / 32);
    r.subt = 5'(elapsed % 32);
    return r;
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned v);
    logic [7:0] b;
    b[7:4] = 4'(v / 10);
    b[3:0] = 4'(v % 10);
    return b;
  endfunction

  // returns {date_word, time_word}, spare bits clear
  function automatic logic [46:0] pack_calendar(int unsigned yr, int unsigned mon,
                                                int unsigned day, int unsigned hrs,
                                                int unsigned mins, int unsigned sec);
    logic [7:0] yb, mob, db, hb, mb, sb;
    yb = to_bcd(yr);
    mob = to_bcd(mon);
    db = to_bcd(day);
    hb = to_bcd(hrs);
    mb = to_bcd(mins);
    sb = to_bcd(sec);
    return {yb, 3'b0, mob[4:0], 2'b0, db[5:0], 1'b0, hb[5:0], 1'b0, mb[6:0], 1'b0, sb[6:0]};
  endfunction

  function automatic logic [46:0] random_calendar();
    int unsigned yr, mon, day, mdays, pick;
    logic [46:0] snap;
    pick = $urandom_range(0, 9);
    if (pick == 0) return {24'($urandom), 23'($urandom)};
    yr = $urandom_range(0, 99);
    mon = $urandom_range(1, 12);
    mdays = (mon == 2 && yr % 4 == 0) ? 29 : month_len[mon-1];
    day = ($urandom_range(0, 3) == 0) ? mdays : $urandom_range(1, mdays);
    snap = pack_calendar(yr, mon, day, $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59));
    snap |= {DateSpareBits & 24'($urandom), TimeSpareBits & 23'($urandom)};
    if (pick == 1) snap[4 * $urandom_range(0, 10) +: 4] = 4'($urandom_range(0, 15));
    return snap;
  endfunction

  function automatic logic [14:0] random_down();
    if (rtc_freq != 0 && $urandom_range(0, 6) != 0) begin
      return 15'($urandom_range(0, (rtc_freq > 16'd32768) ? 32767 : rtc_freq - 1));
    end
    return 15'($urandom_range(0, 32767));
  endfunction

  task automatic send_snapshot(logic [22:0] tw, logic [23:0] dw, logic [14:0] down);
    tick_result_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, down, dw, tw};
    do @(posedge clk); while (!s_axis_tready);
    want = convert_snapshot(rtc_freq, tw, dw, down);
    expected_ticks.push_back(want);
    snapshots_sent++;
    if (want.invalid) invalid_sent++;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_calendar(logic [46:0] snap, logic [14:0] down);
    send_snapshot(snap[22:0], snap[46:23], down);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_clock_frequency(logic [15:0] freq);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= freq;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rtc_freq = freq;
    freq_settings++;
  endtask

  task automatic test_calendar_edges();
    logic [46:0] snap;
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_calendar(pack_calendar(0, 1, 1, 0, 0, 0), 15'd32767);
    send_calendar(pack_calendar(0, 1, 1, 0, 0, 0), 15'd0);
    send_calendar(pack_calendar(99, 12, 31, 23, 59, 59), 15'd0);
    send_calendar(pack_calendar(0, 2, 29, 12, 30, 30), 15'd16384);
    send_calendar(pack_calendar(0, 3, 1, 0, 0, 1), 15'd31);
    send_calendar(pack_calendar(1, 2, 28, 23, 59, 59), 15'd32);
    send_calendar(pack_calendar(1, 2, 29, 0, 0, 0), 15'd100);
    send_calendar(pack_calendar(4, 12, 31, 1, 2, 3), 15'd5000);
    send_calendar(pack_calendar(96, 2, 29, 7, 8, 9), 15'd1);
    send_calendar(pack_calendar(50, 6, 15, 10, 20, 30) | {DateSpareBits, TimeSpareBits},
                  15'd12345);
    send_calendar(pack_calendar(10, 5, 5, 5, 5, 60), 15'd0);
    send_calendar(pack_calendar(10, 5, 5, 5, 60, 5), 15'd0);
    send_calendar(pack_calendar(10, 5, 5, 24, 5, 5), 15'd0);
    send_calendar(pack_calendar(10, 0, 5, 5, 5, 5), 15'd0);
    send_calendar(pack_calendar(10, 13, 5, 5, 5, 5), 15'd0);
    send_calendar(pack_calendar(10, 5, 0, 5, 5, 5), 15'd0);
    send_calendar(pack_calendar(10, 4, 31, 5, 5, 5), 15'd0);
    snap = pack_calendar(10, 5, 5, 5, 5, 5);
    snap[3:0] = 4'hA;
    send_calendar(snap, 15'd0);
    snap = pack_calendar(10, 5, 5, 5, 5, 5);
    snap[11:8] = 4'hB;
    send_calendar(snap, 15'd0);
    snap = pack_calendar(10, 5, 5, 5, 5, 5);
    snap[46:43] = 4'hA;
    send_calendar(snap, 15'd0);
  endtask

  task automatic test_frequency_edges();
    logic [46:0] snap;
    snap = pack_calendar(24, 7, 4, 13, 14, 15);
    set_clock_frequency(16'd0);
    send_calendar(snap, 15'd0);
    set_clock_frequency(16'd1);
    send_calendar(snap, 15'd0);
    send_calendar(snap, 15'd1);
    set_clock_frequency(16'd31);
    send_calendar(snap, 15'd0);
    send_calendar(snap, 15'd31);
    set_clock_frequency(16'd32);
    send_calendar(snap, 15'd0);
    send_calendar(snap, 15'd31);
    send_calendar(snap, 15'd32);
    set_clock_frequency(16'd65535);
    send_calendar(pack_calendar(99, 12, 31, 23, 59, 59), 15'd0);
    send_calendar(snap, 15'd32767);
  endtask

  task automatic test_random_snapshots(int count, logic [15:0] freq, bit with_gaps);
    logic [46:0] snap;
    set_clock_frequency(freq);
    src_gaps = with_gaps;
    sink_stalls = with_gaps;
    repeat (count) begin
      snap = random_calendar();
      send_calendar(snap, random_down());
    end
  endtask

  task automatic test_output_holdoff();
    set_clock_frequency(16'd32768);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    holdoff_cycles = 300;
    repeat (40) send_calendar(random_calendar(), random_down());
  endtask

  // output ready: random stall bursts, or one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (holdoff_cycles > 0) begin
        n = holdoff_cycles;
        holdoff_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.tick = m_axis_tdata[41:0];
      got.subt = m_axis_tdata[46:42];
      got.invalid = m_axis_tuser;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transfer: tick %0d subticks %0d invalid %0d",
                   got.tick, got.subt, got.invalid);
        end
      end else begin
        want = expected_ticks.pop_front();
        if (got.tick != want.tick || got.subt != want.subt || got.invalid != want.invalid) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected tick %0d subticks %0d invalid %0d, got %0d %0d %0d",
                     results_checked, want.tick, want.subt, want.invalid,
                     got.tick, got.subt, got.invalid);
          end
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_ticks.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_calendar_edges();
    test_frequency_edges();
    test_random_snapshots(250, 16'd32768, 1'b1);
    test_random_snapshots(250, 16'($urandom_range(32, 32768)), 1'b1);
    test_output_holdoff();
    test_random_snapshots(200, 16'd65535, 1'b1);
    test_random_snapshots(150, 16'($urandom_range(1, 31)), 1'b1);
    test_random_snapshots(100, 16'd32, 1'b1);
    test_random_snapshots(250, 16'd32768, 1'b0);
    wait_idle();
    $display("Converted %0d snapshots (%0d out of range) under %0d clock frequency settings,",
             snapshots_sent, invalid_sent, freq_settings);
    $display("with random stalls on both sides and a 300-cycle output hold-off.");
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
